// ===== rtl/core/bds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants of the box downscaler
// Register codes, field widths and the tags that travel with each pixel item.
// ----------------------------------------------------------------------------
package bds_pkg;

  // Default sizing of the line buffer and of the block side
  localparam int MAX_LINE_DEF   = 4096;
  localparam int MAX_FACTOR_DEF = 16;

  // Frame height limit and register widths
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int HGT_W        = $clog2(HEIGHT_LIMIT + 1);
  localparam int DIM_W        = 13;
  localparam int FACTOR_W     = 5;
  localparam int PIX_W        = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  // Result queue depth
  localparam int QDEPTH = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IN_WIDTH  = 2'd0,
    REG_IN_HEIGHT = 2'd1,
    REG_FACTOR    = 2'd2
  } bds_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bds_pix_t;

  // Line and frame marks of an output pixel
  typedef struct packed {
    logic eol;
    logic eof;
  } bds_mark_t;

  // Control tag of one input pixel on its way through the sum memory
  typedef struct packed {
    logic      active;
    logic      first;
    logic      emit;
    bds_mark_t mark;
  } bds_tag_t;

endpackage
`default_nettype wire

// ===== rtl/core/box_downscale_rgb24.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_downscale_rgb24: integer box-filter downscaler for 24-bit pixels
// Averages each factor-by-factor block of a raster pixel stream per channel,
// keeping running column sums of the current band in one memory.
//
//   channel  | dir | handshake            | payload
//   cfg      | in  | cfg_we               | cfg_index, cfg_data
//   in       | in  | in_valid / in_ready  | blue_in, green_in, red_in
//   out      | out | out_valid / out_ready| blue_out, green_out, red_out,
//            |     |                      | end_of_line, end_of_frame
//
// One pixel per clock while in_ready is high: the column sum memory is read
// when a pixel enters and written back the next cycle, with forwarding between
// neighbors. Each result passes the add stage and the sum and product
// registers into the result queue before it is offered. After reset and
// after every configuration write, in_ready stays low while the serial divider
// rebuilds output sizes, block positions and the area reciprocal.
// Up to QDEPTH results are held against a stalled output; then in_ready drops.
// ----------------------------------------------------------------------------
module box_downscale_rgb24 #(
  parameter int MAX_LINE   = bds_pkg::MAX_LINE_DEF,
  parameter int MAX_FACTOR = bds_pkg::MAX_FACTOR_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bds_pkg::PIX_W-1:0]       blue_in,
  input  logic [bds_pkg::PIX_W-1:0]       green_in,
  input  logic [bds_pkg::PIX_W-1:0]       red_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bds_pkg::PIX_W-1:0]       blue_out,
  output logic [bds_pkg::PIX_W-1:0]       green_out,
  output logic [bds_pkg::PIX_W-1:0]       red_out,
  output logic                            end_of_line,
  output logic                            end_of_frame
);

  import bds_pkg::*;

  localparam int CW     = $clog2(MAX_LINE);
  localparam int WW     = $clog2(MAX_LINE + 1);
  localparam int IW     = $clog2(MAX_FACTOR);
  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int AREA_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int SW     = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
  localparam int KSH    = SW + AREA_W;
  localparam int MW     = KSH + 1;
  localparam int CLW    = (WW > DIM_W) ? WW : DIM_W;
  localparam int FCW    = (FW > FACTOR_W) ? FW : FACTOR_W;
  localparam int DVW    = (CLW > MW) ? CLW : MW;
  localparam int RCW    = $clog2(QDEPTH + 1);
  localparam logic [DVW-1:0] RECIP_BASE = DVW'(1) << KSH;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DIV_W,
    ST_DIV_H,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_DIV_RECIP
  } state_t;

  // Configuration registers
  logic [DIM_W-1:0]    in_width;
  logic [DIM_W-1:0]    in_height;
  logic [FACTOR_W-1:0] factor;

  // Effective sizes
  logic [WW-1:0]     w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic [FW-1:0]     f_eff;
  logic [FW-1:0]     f_last;
  logic [AREA_W-1:0] area;

  // Raster position
  logic [CW-1:0]    column_pos;
  logic [ROW_W-1:0] row_pos;
  logic [IW-1:0]    col_in_block;
  logic [IW-1:0]    row_in_band;

  // Derived position and sizes, rebuilt by the divider
  logic [CW-1:0]    ocol;
  logic [IW-1:0]    col_rem;
  logic [ROW_W-1:0] oband;
  logic [IW-1:0]    row_rem;
  logic [WW-1:0]    out_w;
  logic [HGT_W-1:0] out_h;
  logic [MW-1:0]    recip;

  state_t state;
  logic   div_go;
  logic   div_done;
  logic   div_fin;
  logic [DVW-1:0]    div_dividend;
  logic [AREA_W-1:0] div_divisor;
  logic [DVW-1:0]    div_quo;
  logic [AREA_W-1:0] div_rem;

  logic     accept;
  logic     pop;
  logic     col_wrap, row_wrap, cib_wrap, rib_wrap, cr_last, rr_last;
  logic     eol_now;
  bds_tag_t in_tag;
  bds_pix_t in_pix;
  logic [RCW-1:0] res_cnt;

  logic               sum_valid;
  logic [SW-1:0]      sum_blue, sum_green, sum_red;
  bds_mark_t          sum_mark;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= DIM_W'(1);
      in_height <= DIM_W'(1);
      factor    <= FACTOR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_WIDTH:  in_width  <= cfg_data[DIM_W-1:0];
        REG_IN_HEIGHT: in_height <= cfg_data[DIM_W-1:0];
        REG_FACTOR:    factor    <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into their legal ranges
  always_comb begin
    if (in_width == '0) begin
      w_eff = WW'(1);
    end else if (CLW'(in_width) > CLW'(MAX_LINE)) begin
      w_eff = WW'(MAX_LINE);
    end else begin
      w_eff = WW'(in_width);
    end
    if (in_height == '0) begin
      h_eff = HGT_W'(1);
    end else if (in_height > DIM_W'(HEIGHT_LIMIT)) begin
      h_eff = HGT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = HGT_W'(in_height);
    end
    if (factor == '0) begin
      f_eff = FW'(1);
    end else if (FCW'(factor) > FCW'(MAX_FACTOR)) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(factor);
    end
  end

  assign f_last = f_eff - FW'(1);
  assign area   = AREA_W'(AREA_W'(f_eff) * AREA_W'(f_eff));

  // Wrap conditions of the position counters
  assign col_wrap = (WW'(column_pos) >= w_eff - WW'(1));
  assign row_wrap = (HGT_W'(row_pos) >= h_eff - HGT_W'(1));
  assign cib_wrap = (FW'(col_in_block) >= f_last);
  assign rib_wrap = (FW'(row_in_band) >= f_last);
  assign cr_last  = (FW'(col_rem) == f_last);
  assign rr_last  = (FW'(row_rem) == f_last);

  // Classify the incoming pixel
  assign eol_now          = (WW'(ocol) == out_w - WW'(1));
  assign in_tag.active    = (WW'(ocol) < out_w) && (HGT_W'(oband) < out_h);
  assign in_tag.first     = (col_in_block == '0) && (row_in_band == '0);
  assign in_tag.emit      = in_tag.active && (FW'(row_in_band) == f_last)
                            && (FW'(col_in_block) == f_last);
  assign in_tag.mark.eol  = eol_now;
  assign in_tag.mark.eof  = eol_now && (HGT_W'(oband) == out_h - HGT_W'(1));

  assign in_pix.blue  = blue_in;
  assign in_pix.green = green_in;
  assign in_pix.red   = red_in;

  assign in_ready = (state == ST_RUN) && (res_cnt < RCW'(QDEPTH));
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Advance the raster position on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos   <= '0;
      row_pos      <= '0;
      col_in_block <= '0;
      row_in_band  <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_pos   <= '0;
        col_in_block <= '0;
        if (row_wrap) begin
          row_pos     <= '0;
          row_in_band <= '0;
        end else begin
          row_pos     <= row_pos + ROW_W'(1);
          row_in_band <= rib_wrap ? '0 : row_in_band + IW'(1);
        end
      end else begin
        column_pos   <= column_pos + CW'(1);
        col_in_block <= cib_wrap ? '0 : col_in_block + IW'(1);
      end
    end
  end

  // Select divider operands for the current rebuild step
  always_comb begin
    div_dividend = '0;
    div_divisor  = AREA_W'(f_eff);
    case (state)
      ST_DIV_W:     div_dividend = DVW'(w_eff);
      ST_DIV_H:     div_dividend = DVW'(h_eff);
      ST_DIV_COL:   div_dividend = DVW'(column_pos);
      ST_DIV_ROW:   div_dividend = DVW'(row_pos);
      ST_DIV_RECIP: begin
        div_dividend = RECIP_BASE + DVW'(area) - DVW'(1);
        div_divisor  = area;
      end
      default: ;
    endcase
  end

  // Take a quotient only from a division started by the current step
  assign div_fin = div_done && !div_go;

  // Rebuild sequencer; step block positions while running
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_DIV_W;
      div_go <= 1'b1;
    end else if (cfg_we) begin
      state  <= ST_DIV_W;
      div_go <= 1'b1;
    end else begin
      div_go <= 1'b0;
      case (state)
        ST_RUN: begin
          if (accept) begin
            if (col_wrap) begin
              ocol    <= '0;
              col_rem <= '0;
              if (row_wrap) begin
                oband   <= '0;
                row_rem <= '0;
              end else if (rr_last) begin
                oband   <= oband + ROW_W'(1);
                row_rem <= '0;
              end else begin
                row_rem <= row_rem + IW'(1);
              end
            end else if (cr_last) begin
              ocol    <= ocol + CW'(1);
              col_rem <= '0;
            end else begin
              col_rem <= col_rem + IW'(1);
            end
          end
        end
        ST_DIV_W: begin
          if (div_fin) begin
            out_w  <= WW'(div_quo);
            state  <= ST_DIV_H;
            div_go <= 1'b1;
          end
        end
        ST_DIV_H: begin
          if (div_fin) begin
            out_h  <= HGT_W'(div_quo);
            state  <= ST_DIV_COL;
            div_go <= 1'b1;
          end
        end
        ST_DIV_COL: begin
          if (div_fin) begin
            ocol    <= CW'(div_quo);
            col_rem <= IW'(div_rem);
            state   <= ST_DIV_ROW;
            div_go  <= 1'b1;
          end
        end
        ST_DIV_ROW: begin
          if (div_fin) begin
            oband   <= ROW_W'(div_quo);
            row_rem <= IW'(div_rem);
            state   <= ST_DIV_RECIP;
            div_go  <= 1'b1;
          end
        end
        ST_DIV_RECIP: begin
          if (div_fin) begin
            recip <= MW'(div_quo);
            state <= ST_RUN;
          end
        end
        default: begin
          state  <= ST_DIV_W;
          div_go <= 1'b1;
        end
      endcase
    end
  end

  // Reserve a queue slot for every result in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else begin
      res_cnt <= res_cnt + RCW'(accept && in_tag.emit) - RCW'(pop);
    end
  end

  bds_divider #(
    .DVW (DVW),
    .DSW (AREA_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  bds_accum #(
    .DEPTH  (MAX_LINE),
    .ADDR_W (CW),
    .SW     (SW)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (ocol),
    .tag_in    (in_tag),
    .pix_in    (in_pix),
    .sum_valid (sum_valid),
    .sum_blue  (sum_blue),
    .sum_green (sum_green),
    .sum_red   (sum_red),
    .sum_mark  (sum_mark)
  );

  bds_scale #(
    .SW  (SW),
    .MW  (MW),
    .KSH (KSH)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_blue     (sum_blue),
    .sum_green    (sum_green),
    .sum_red      (sum_red),
    .sum_mark     (sum_mark),
    .recip        (recip),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blue_out     (blue_out),
    .green_out    (green_out),
    .red_out      (red_out),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
  );

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("item taken during the rebuild after a register write");

  a_reserve_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RCW'(QDEPTH))
    else $error("more results reserved than queue slots");

  a_reserve_taken: assert property (@(posedge clk) disable iff (rst)
    (accept && in_tag.emit) |=> (res_cnt != '0))
    else $error("emitting item without a reserved slot");

endmodule
`default_nettype wire

// ===== rtl/core/bds_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bds_divider: serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module bds_divider #(
  parameter int DVW = 26,
  parameter int DSW = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient,
  output logic [DSW-1:0] remainder
);

  localparam int CNTW = $clog2(DVW);

  logic            busy;
  logic [CNTW-1:0] step;
  logic [DVW-1:0]  quo;
  logic [DSW-1:0]  rem;
  logic [DSW-1:0]  dsr;
  logic [DSW:0]    trial;
  logic            fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[DVW-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Track busy and flag the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == CNTW'(DVW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Load operands, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      quo  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      step <= step + CNTW'(1);
      quo  <= {quo[DVW-2:0], fits};
      rem  <= fits ? DSW'(trial - {1'b0, dsr}) : trial[DSW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== rtl/core/bds_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bds_accum: column sum memory with read-modify-write
// Reads the column entry when an item enters, adds the pixel in the next cycle
// and writes back, forwarding the previous write when both hit one entry.
// ----------------------------------------------------------------------------
module bds_accum #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int SW     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  bds_pkg::bds_tag_t tag_in,
  input  bds_pkg::bds_pix_t pix_in,
  output logic              sum_valid,
  output logic [SW-1:0]     sum_blue,
  output logic [SW-1:0]     sum_green,
  output logic [SW-1:0]     sum_red,
  output bds_pkg::bds_mark_t sum_mark
);

  import bds_pkg::*;

  localparam int WORD_W = 3 * SW;

  logic [WORD_W-1:0] sum_mem [DEPTH];

  logic              s2_v;
  logic [ADDR_W-1:0] s2_addr;
  bds_tag_t          s2_tag;
  bds_pix_t          s2_pix;
  logic [WORD_W-1:0] rd_word;

  logic              wr_v;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic [WORD_W-1:0] base_word;
  logic [SW-1:0]     base_b, base_g, base_r;
  logic [SW-1:0]     new_b, new_g, new_r;
  logic              do_write;

  // Forward the write of the previous cycle when it hit the same entry
  assign base_word = (wr_v && wr_addr == s2_addr) ? wr_word : rd_word;
  assign base_b    = base_word[WORD_W-1 -: SW];
  assign base_g    = base_word[2*SW-1 -: SW];
  assign base_r    = base_word[SW-1:0];

  // Start a fresh sum on the first pixel of a block, else accumulate
  assign new_b = s2_tag.first ? SW'(s2_pix.blue)  : base_b + SW'(s2_pix.blue);
  assign new_g = s2_tag.first ? SW'(s2_pix.green) : base_g + SW'(s2_pix.green);
  assign new_r = s2_tag.first ? SW'(s2_pix.red)   : base_r + SW'(s2_pix.red);

  assign do_write = s2_v && s2_tag.active;

  // Memory port: registered read, write back from the add stage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= sum_mem[rd_addr];
    end
    if (do_write) begin
      sum_mem[s2_addr] <= {new_b, new_g, new_r};
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v      <= 1'b0;
      wr_v      <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      s2_v      <= rd_en;
      wr_v      <= do_write;
      sum_valid <= s2_v && s2_tag.emit;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_addr <= rd_addr;
      s2_tag  <= tag_in;
      s2_pix  <= pix_in;
    end
    if (do_write) begin
      wr_addr <= s2_addr;
      wr_word <= {new_b, new_g, new_r};
    end
    sum_blue  <= new_b;
    sum_green <= new_g;
    sum_red   <= new_r;
    sum_mark  <= s2_tag.mark;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bds_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bds_scale: block average and result queue
// Multiplies each block sum by the reciprocal of the block area, keeps the
// integer part and queues the finished pixel for the output channel.
// ----------------------------------------------------------------------------
module bds_scale #(
  parameter int SW  = 16,
  parameter int MW  = 26,
  parameter int KSH = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sum_valid,
  input  logic [SW-1:0]      sum_blue,
  input  logic [SW-1:0]      sum_green,
  input  logic [SW-1:0]      sum_red,
  input  bds_pkg::bds_mark_t sum_mark,
  input  logic [MW-1:0]      recip,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [bds_pkg::PIX_W-1:0] blue_out,
  output logic [bds_pkg::PIX_W-1:0] green_out,
  output logic [bds_pkg::PIX_W-1:0] red_out,
  output logic               end_of_line,
  output logic               end_of_frame
);

  import bds_pkg::*;

  localparam int PW  = SW + MW;
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef struct packed {
    bds_pix_t  pix;
    bds_mark_t mark;
  } res_t;

  logic          prod_v;
  logic [PW-1:0] prod_b, prod_g, prod_r;
  bds_mark_t     prod_mark;

  res_t           q_mem [QDEPTH];
  res_t           q_head;
  res_t           q_in;
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] q_count;
  logic           push, pop;

  // Multiply by the area reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_b    <= PW'(sum_blue)  * PW'(recip);
    prod_g    <= PW'(sum_green) * PW'(recip);
    prod_r    <= PW'(sum_red)   * PW'(recip);
    prod_mark <= sum_mark;
  end

  // Drop the fraction and keep the low byte of the quotient
  assign q_in.pix.blue  = prod_b[KSH +: PIX_W];
  assign q_in.pix.green = prod_g[KSH +: PIX_W];
  assign q_in.pix.red   = prod_r[KSH +: PIX_W];
  assign q_in.mark      = prod_mark;

  assign push = prod_v;
  assign pop  = out_valid && out_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= q_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      q_count <= q_count + QCW'(push) - QCW'(pop);
    end
  end

  assign q_head       = q_mem[rd_ptr];
  assign out_valid    = (q_count != '0);
  assign blue_out     = q_head.pix.blue;
  assign green_out    = q_head.pix.green;
  assign red_out      = q_head.pix.red;
  assign end_of_line  = q_head.mark.eol;
  assign end_of_frame = q_head.mark.eof;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_count == QCW'(QDEPTH) && !pop) |-> !push)
    else $error("result queue overflow");

  a_prod_follows: assert property (@(posedge clk) disable iff (rst)
    sum_valid |=> prod_v)
    else $error("block sum lost before the multiply stage");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (q_count == $past(q_count) - QCW'(1)))
    else $error("queue count out of step with pops");

endmodule
`default_nettype wire
